// ===== hdl/assert_macros.svh =====
// assertion macros used by the sorted keyframe table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/skt_pkg.sv =====
// types and constants of the sorted keyframe table
package skt_pkg;

    localparam int DEPTH = 64;
    localparam int KEY_W = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] CMD_QUERY  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_RANGE     = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STATUS_FULL      = 2'd3;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2
    } cell_op_t;

    typedef struct packed {
        logic     capture;
        cell_op_t op;
    } cell_ctl_t;

endpackage

// ===== hdl/sorted_keyframe_table.sv =====
// sorted keyframe table: control, result register and the chain of cells
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  command  | cmd_valid, cmd_stall   | command, key_time, forward
//  result   | result_valid, result_stall | first_index, second_index,
//           |                        | was_inserted, status
//
// in a transaction every cell compares its key with key_time in the
// accept cycle, then the cells shift and the result register loads
// reset clears the entry count, the state and the result valid; no clearing pass
// cmd_stall is high from each accept until the cells update
// the update waits while a result is held under result_stall
module sorted_keyframe_table
    import skt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    output logic                    cmd_stall,
    input  logic [1:0]              command,
    input  logic signed [KEY_W-1:0] key_time,
    input  logic                    forward,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic [IDX_W-1:0]        first_index,
    output logic [IDX_W-1:0]        second_index,
    output logic                    was_inserted,
    output logic [1:0]              status
);

`include "assert_macros.svh"

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [1:0]              cmd_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic                    fwd_reg;
    logic                    result_valid_reg;
    logic                    result_valid_next;
    logic [IDX_W-1:0]        first_reg;
    logic [IDX_W-1:0]        second_reg;
    logic                    ins_reg;
    logic [1:0]              status_reg;

    logic [IDX_W-1:0]        first_next;
    logic [IDX_W-1:0]        second_next;
    logic                    ins_next;
    logic [1:0]              status_next;

    logic                    accept;
    logic                    exec_fire;
    logic                    do_insert;
    logic                    do_delete;
    cell_ctl_t               ctl;

    logic signed [KEY_W-1:0] key_vec [DEPTH];
    logic [DEPTH-1:0]        lt_vec;
    logic [DEPTH-1:0]        eq_vec;

    logic [CNT_W-1:0]        pos;
    logic [IDX_W-1:0]        pos_idx;
    logic                    hit;
    logic                    out_of_range;

    assign accept    = (state_reg == ST_IDLE) && cmd_valid;
    assign exec_fire = (state_reg == ST_EXEC) && (!result_valid_reg || !result_stall);
    assign cmd_stall = (state_reg != ST_IDLE);

    // lower bound from the thermometer of less-than flags
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (((i == 0) ? 1'b1 : lt_vec[(i == 0) ? 0 : i - 1]) && !lt_vec[i])
                pos = pos | CNT_W'(i);
        end
        if (lt_vec[DEPTH-1])
            pos = CNT_W'(DEPTH);
    end

    assign pos_idx      = pos[IDX_W-1:0];
    assign hit          = |eq_vec;
    assign out_of_range = (count_reg == '0) || (pos == count_reg) ||
                          ((pos == '0) && !hit);

    always_comb
    begin
        first_next  = '0;
        second_next = '0;
        ins_next    = 1'b0;
        status_next = STATUS_OK;
        do_insert   = 1'b0;
        do_delete   = 1'b0;
        unique case (cmd_reg)
            CMD_QUERY:
            begin
                if (out_of_range)
                    status_next = STATUS_RANGE;
                else if (hit && fwd_reg)
                begin
                    first_next  = pos_idx;
                    second_next = ((pos + 1'b1) < count_reg) ? pos_idx + 1'b1 : pos_idx;
                end
                else if (hit)
                begin
                    first_next  = (pos == '0) ? '0 : pos_idx - 1'b1;
                    second_next = pos_idx;
                end
                else
                begin
                    first_next  = pos_idx - 1'b1;
                    second_next = pos_idx;
                end
            end
            CMD_INSERT:
            begin
                if (hit)
                    first_next = pos_idx;
                else if (count_reg == CNT_W'(DEPTH))
                    status_next = STATUS_FULL;
                else
                begin
                    first_next = pos_idx;
                    ins_next   = 1'b1;
                    do_insert  = 1'b1;
                end
            end
            CMD_DELETE:
            begin
                if (hit)
                begin
                    first_next = pos_idx;
                    do_delete  = 1'b1;
                end
                else
                    status_next = STATUS_NOT_FOUND;
            end
            default:
            begin
                status_next = STATUS_OK;
            end
        endcase
    end

    always_comb
    begin
        ctl.capture = accept;
        ctl.op      = OP_HOLD;
        if (exec_fire && do_insert)
            ctl.op = OP_INSERT;
        else if (exec_fire && do_delete)
            ctl.op = OP_DELETE;
    end

    always_comb
    begin
        count_next = count_reg;
        if (exec_fire && do_insert)
            count_next = count_reg + 1'b1;
        else if (exec_fire && do_delete)
            count_next = count_reg - 1'b1;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_EXEC;
            ST_EXEC: if (exec_fire) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign result_valid_next = exec_fire ? 1'b1 : (result_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command;
            key_reg <= key_time;
            fwd_reg <= forward;
        end
        if (exec_fire)
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
            ins_reg    <= ins_next;
            status_reg <= status_next;
        end
    end

    // chain of cells
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic                    left_lt;
        logic signed [KEY_W-1:0] left_key;
        logic signed [KEY_W-1:0] right_key;

        if (g == 0)
        begin : g_first
            assign left_lt  = 1'b1;
            assign left_key = key_reg;
        end
        else
        begin : g_mid
            assign left_lt  = lt_vec[g-1];
            assign left_key = key_vec[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_key = key_vec[g];
        end
        else
        begin : g_inner
            assign right_key = key_vec[g+1];
        end

        skt_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .valid     (CNT_W'(g) < count_reg),
            .cmp_key   (key_time),
            .wr_key    (key_reg),
            .left_lt   (left_lt),
            .left_key  (left_key),
            .right_key (right_key),
            .key       (key_vec[g]),
            .lt        (lt_vec[g]),
            .eq        (eq_vec[g])
        );
    end

    assign result_valid = result_valid_reg;
    assign first_index  = first_reg;
    assign second_index = second_reg;
    assign was_inserted = ins_reg;
    assign status       = status_reg;

    `ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(DEPTH))
    `ASSERT_IMPL(a_lt_thermometer, state_reg == ST_EXEC,
                 ((lt_vec + DEPTH'(1)) & lt_vec) == '0)
    `ASSERT_IMPL(a_eq_single, state_reg == ST_EXEC, $onehot0(eq_vec))
    `ASSERT_NEXT(a_insert_count, exec_fire && do_insert,
                 count_reg == $past(count_reg) + 1'b1)

endmodule

// ===== hdl/skt_cell.sv =====
// one table cell: holds a key, compares it and shifts with its neighbors
module skt_cell
    import skt_pkg::*;
(
    input  logic                    clk,
    input  cell_ctl_t               ctl,
    input  logic                    valid,
    input  logic signed [KEY_W-1:0] cmp_key,
    input  logic signed [KEY_W-1:0] wr_key,
    input  logic                    left_lt,
    input  logic signed [KEY_W-1:0] left_key,
    input  logic signed [KEY_W-1:0] right_key,
    output logic signed [KEY_W-1:0] key,
    output logic                    lt,
    output logic                    eq
);

    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;
    logic                    lt_reg;
    logic                    lt_next;
    logic                    eq_reg;
    logic                    eq_next;

    always_comb
    begin
        lt_next = lt_reg;
        eq_next = eq_reg;
        if (ctl.capture)
        begin
            lt_next = valid && (key_reg < cmp_key);
            eq_next = valid && (key_reg == cmp_key);
        end
    end

    always_comb
    begin
        unique case (ctl.op)
            OP_HOLD:   key_next = key_reg;
            OP_INSERT: key_next = lt_reg ? key_reg : (left_lt ? wr_key : left_key);
            OP_DELETE: key_next = lt_reg ? key_reg : right_key;
            default:   key_next = key_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        lt_reg  <= lt_next;
        eq_reg  <= eq_next;
    end

    assign key = key_reg;
    assign lt  = lt_reg;
    assign eq  = eq_reg;

endmodule
